FILE: rtl/alu_pkg.sv
// ----------------------------------------------------------------------------
// alu_pkg
// Shared types and operation codes for the 32-bit integer ALU.
// ----------------------------------------------------------------------------
package alu_pkg;

	localparam int unsigned Width      = 32;
	localparam int unsigned CmdWidth   = 5;
	localparam int unsigned DivStages  = Width;

	typedef enum logic [CmdWidth-1:0] {
		CMD_ADD      = 5'd0,
		CMD_SUB      = 5'd1,
		CMD_MUL      = 5'd2,
		CMD_DIV      = 5'd3,
		CMD_MOD      = 5'd4,
		CMD_SADD     = 5'd5,
		CMD_SSUB     = 5'd6,
		CMD_SMUL     = 5'd7,
		CMD_SDIV     = 5'd8,
		CMD_SMOD     = 5'd9,
		CMD_AND      = 5'd10,
		CMD_NAND     = 5'd11,
		CMD_OR       = 5'd12,
		CMD_NOR      = 5'd13,
		CMD_XOR      = 5'd14,
		CMD_XNOR     = 5'd15,
		CMD_NOT      = 5'd16,
		CMD_IMPLIES  = 5'd17,
		CMD_NIMPLIES = 5'd18,
		CMD_SHL      = 5'd19,
		CMD_SHR      = 5'd20,
		CMD_SRA      = 5'd21,
		CMD_ROL      = 5'd22,
		CMD_ROR      = 5'd23,
		CMD_SLT      = 5'd24,
		CMD_ULT      = 5'd25
	} cmd_t;

	// One slot of the divider pipe; the non-divide result rides along.
	typedef struct packed {
		logic             vld;
		cmd_t             cmd;
		logic [Width-1:0] fast;
		logic [Width-1:0] rem;
		logic [Width-1:0] qd;    // dividend bits shift out, quotient bits shift in
		logic [Width-1:0] dvs;
		logic             neg_q;
		logic             neg_r;
		logic             bz;
	} div_slot_t;

endpackage

FILE: rtl/alu_32bit_arith_logic_shift.sv
// ----------------------------------------------------------------------------
// alu_32bit_arith_logic_shift
// Pipelined 32-bit ALU: arithmetic, multiply, divide, logic, shifts, compares.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_stall  | command, operand_a, operand_b
//  output   | out_valid / out_stall| result
//
//  One transaction in per cycle, one result out per cycle, in order, while
//  out_stall does not hold the pipe. Stages: input register, operand/fast-op
//  stage, 32 restoring divide stages (one quotient bit each), output register.
//  The whole pipe moves as one; it holds when a result waits under out_stall,
//  and bubbles are squeezed out only at the output register.
//  Reset clears every valid bit; no clearing pass is needed.
//
module alu_32bit_arith_logic_shift (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [alu_pkg::CmdWidth-1:0]   command,
	input  logic [alu_pkg::Width-1:0]      operand_a,
	input  logic [alu_pkg::Width-1:0]      operand_b,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [alu_pkg::Width-1:0]      result
);
	import alu_pkg::*;

	logic en;

	// stage 1: input capture
	logic             vld_s1;
	cmd_t             cmd_s1;
	logic [Width-1:0] a_s1, b_s1;

	// divider pipe; slot 0 is stage 2
	div_slot_t div_s [0:DivStages];

	logic             out_valid_q;
	logic [Width-1:0] result_q;
	cmd_t             out_cmd_q;
	logic             out_bz_q;

	// Global advance: pipe moves unless a result is held by the consumer.
	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_t'(command);
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	// stage 2: fast (non-divide) ops plus divider operand prep
	logic [Width-1:0] fast_c;
	logic             sgn_c;
	div_slot_t        load_c;

	always_comb begin
		case (cmd_s1)
			CMD_ADD, CMD_SADD: fast_c = a_s1 + b_s1;
			CMD_SUB, CMD_SSUB: fast_c = a_s1 - b_s1;
			CMD_MUL, CMD_SMUL: fast_c = a_s1 * b_s1;
			CMD_AND:           fast_c = a_s1 & b_s1;
			CMD_NAND:          fast_c = ~(a_s1 & b_s1);
			CMD_OR:            fast_c = a_s1 | b_s1;
			CMD_NOR:           fast_c = ~(a_s1 | b_s1);
			CMD_XOR:           fast_c = a_s1 ^ b_s1;
			CMD_XNOR:          fast_c = ~(a_s1 ^ b_s1);
			CMD_NOT:           fast_c = ~a_s1;
			CMD_IMPLIES:       fast_c = ~a_s1 | b_s1;
			CMD_NIMPLIES:      fast_c = a_s1 & ~b_s1;
			CMD_SHL:           fast_c = {a_s1[Width-2:0], 1'b0};
			CMD_SHR:           fast_c = {1'b0, a_s1[Width-1:1]};
			CMD_SRA:           fast_c = {a_s1[Width-1], a_s1[Width-1:1]};
			CMD_ROL:           fast_c = {a_s1[Width-2:0], a_s1[Width-1]};
			CMD_ROR:           fast_c = {a_s1[0], a_s1[Width-1:1]};
			CMD_SLT:           fast_c = Width'($signed(a_s1) < $signed(b_s1));
			CMD_ULT:           fast_c = Width'(a_s1 < b_s1);
			default:           fast_c = '0;
		endcase

		sgn_c        = (cmd_s1 == CMD_SDIV) || (cmd_s1 == CMD_SMOD);
		load_c.vld   = vld_s1;
		load_c.cmd   = cmd_s1;
		load_c.fast  = fast_c;
		load_c.rem   = '0;
		load_c.qd    = (sgn_c && a_s1[Width-1]) ? (~a_s1 + 1'b1) : a_s1;
		load_c.dvs   = (sgn_c && b_s1[Width-1]) ? (~b_s1 + 1'b1) : b_s1;
		load_c.neg_q = sgn_c && (a_s1[Width-1] ^ b_s1[Width-1]);
		load_c.neg_r = sgn_c && a_s1[Width-1];
		load_c.bz    = (b_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else if (en) begin
			div_s[0] <= load_c;
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar k = 0; k < DivStages; k++) begin : g_div
		logic [Width:0] part_c, diff_c;
		div_slot_t      nxt_c;

		always_comb begin
			part_c = {div_s[k].rem, div_s[k].qd[Width-1]};
			diff_c = part_c - {1'b0, div_s[k].dvs};
			nxt_c  = div_s[k];
			if (!diff_c[Width]) begin
				nxt_c.rem = diff_c[Width-1:0];
				nxt_c.qd  = {div_s[k].qd[Width-2:0], 1'b1};
			end else begin
				nxt_c.rem = part_c[Width-1:0];
				nxt_c.qd  = {div_s[k].qd[Width-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k+1] <= '0;
			end else if (en) begin
				div_s[k+1] <= nxt_c;
			end
		end
	end

	// output: sign fix and select
	div_slot_t        last_c;
	logic [Width-1:0] quo_c, rem_c, sel_c;

	always_comb begin
		last_c = div_s[DivStages];
		quo_c  = last_c.neg_q ? (~last_c.qd + 1'b1) : last_c.qd;
		rem_c  = last_c.neg_r ? (~last_c.rem + 1'b1) : last_c.rem;
		case (last_c.cmd)
			CMD_DIV, CMD_SDIV: sel_c = last_c.bz ? '0 : quo_c;
			CMD_MOD, CMD_SMOD: sel_c = last_c.bz ? '0 : rem_c;
			default:           sel_c = last_c.fast;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last_c.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q  <= sel_c;
			out_cmd_q <= last_c.cmd;
			out_bz_q  <= last_c.bz;
		end
	end

	// compares give only 0 or 1
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_cmd_q == CMD_SLT || out_cmd_q == CMD_ULT)
		|-> result_q[Width-1:1] == '0)
		else $error("compare result wider than one bit");

	// any divide or modulo by zero gives zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bz_q && (out_cmd_q == CMD_DIV || out_cmd_q == CMD_SDIV ||
		out_cmd_q == CMD_MOD || out_cmd_q == CMD_SMOD) |-> result_q == '0)
		else $error("divide by zero result not zero");

	// last divide slot reaches the output when the pipe advances
	assert property (@(posedge clk) disable iff (!arst_n)
		en && div_s[DivStages].vld |=> out_valid_q)
		else $error("transaction lost at output register");

	// a held result keeps the whole pipe frozen
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(div_s[DivStages].vld) && $stable(vld_s1))
		else $error("pipe moved while output held");

endmodule
